// File: design/assert_macros.svh
// Assertion helpers used by the design module sha256_ctrl.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// File: design/sha256_pkg.sv
`default_nettype none

package sha256_pkg;

   localparam logic [2:0] SRC_DATA   = 3'd0;
   localparam logic [2:0] SRC_LAST   = 3'd1;
   localparam logic [2:0] SRC_PAD    = 3'd2;
   localparam logic [2:0] SRC_ZERO   = 3'd3;
   localparam logic [2:0] SRC_LEN_HI = 3'd4;
   localparam logic [2:0] SRC_LEN_LO = 3'd5;

   localparam logic [31:0] PAD_WORD = 32'h8000_0000;

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] INIT_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   typedef struct packed {
      logic       push;
      logic [2:0] src;
      logic       count;
      logic       load_work;
      logic       round;
      logic [5:0] round_idx;
      logic       fold;
      logic [2:0] out_idx;
      logic       restart;
   } sha_cmd_type;

   typedef struct packed {
      logic [3:0] fill;
      logic       last_full;
   } sha_status_type;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

endpackage

`default_nettype wire

// File: design/sha256_dp.sv
`default_nettype none

module sha256_dp (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [39:0]                 req_tdata,
   input  wire logic                        req_tlast,
   output logic [39:0]                      rsp_tdata,
   input  wire sha256_pkg::sha_cmd_type     cmd,
   output sha256_pkg::sha_status_type       status
);

   logic [31:0] hash_ff [8];
   logic [31:0] work_ff [8];
   logic [31:0] sched_ff [16];
   logic [3:0]  fill_ff;
   logic [63:0] bits_ff;
   logic [63:0] bits_in;

   logic [31:0] data_word;
   logic [2:0]  valid_bytes;
   logic [2:0]  nb_sat;
   logic [31:0] last_word;
   logic [31:0] push_word;
   logic [31:0] sched_new;
   logic [31:0] t1;
   logic [31:0] t2;
   logic [5:0]  add_bits;

   assign data_word   = req_tdata[31:0];
   assign valid_bytes = req_tdata[34:32];
   assign nb_sat      = (valid_bytes > 3'd4) ? 3'd4 : valid_bytes;

   always_comb begin
      case (nb_sat)
         3'd0:    last_word = 32'h8000_0000;
         3'd1:    last_word = {data_word[31:24], 24'h80_0000};
         3'd2:    last_word = {data_word[31:16], 16'h8000};
         3'd3:    last_word = {data_word[31:8], 8'h80};
         default: last_word = data_word;
      endcase
   end

   always_comb begin
      case (cmd.src)
         sha256_pkg::SRC_DATA:   push_word = data_word;
         sha256_pkg::SRC_LAST:   push_word = last_word;
         sha256_pkg::SRC_PAD:    push_word = sha256_pkg::PAD_WORD;
         sha256_pkg::SRC_LEN_HI: push_word = bits_ff[63:32];
         sha256_pkg::SRC_LEN_LO: push_word = bits_ff[31:0];
         default:                push_word = 32'h0;
      endcase
   end

   assign sched_new = sha256_pkg::small_sigma1(sched_ff[14]) + sched_ff[9]
                    + sha256_pkg::small_sigma0(sched_ff[1]) + sched_ff[0];

   assign t1 = work_ff[7] + sha256_pkg::big_sigma1(work_ff[4])
             + ((work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]))
             + sha256_pkg::ROUND_K[cmd.round_idx] + sched_ff[0];
   assign t2 = sha256_pkg::big_sigma0(work_ff[0])
             + ((work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2])
                ^ (work_ff[1] & work_ff[2]));

   assign add_bits = req_tlast ? {nb_sat, 3'b000} : 6'd32;

   always_comb begin
      bits_in = bits_ff;
      if (cmd.restart) begin
         bits_in = 64'h0;
      end else if (cmd.count) begin
         bits_in = bits_ff + {58'h0, add_bits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) begin
            hash_ff[i] <= sha256_pkg::INIT_HASH[i];
         end
         fill_ff <= 4'h0;
         bits_ff <= 64'h0;
      end else begin
         if (cmd.restart) begin
            for (int i = 0; i < 8; i++) begin
               hash_ff[i] <= sha256_pkg::INIT_HASH[i];
            end
         end else if (cmd.fold) begin
            for (int i = 0; i < 8; i++) begin
               hash_ff[i] <= hash_ff[i] + work_ff[i];
            end
         end
         if (cmd.push) begin
            fill_ff <= fill_ff + 4'h1;
         end
         bits_ff <= bits_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push || cmd.round) begin
         for (int i = 0; i < 15; i++) begin
            sched_ff[i] <= sched_ff[i + 1];
         end
         sched_ff[15] <= cmd.push ? push_word : sched_new;
      end
      if (cmd.load_work) begin
         for (int i = 0; i < 8; i++) begin
            work_ff[i] <= hash_ff[i];
         end
      end else if (cmd.round) begin
         work_ff[0] <= t1 + t2;
         work_ff[1] <= work_ff[0];
         work_ff[2] <= work_ff[1];
         work_ff[3] <= work_ff[2];
         work_ff[4] <= work_ff[3] + t1;
         work_ff[5] <= work_ff[4];
         work_ff[6] <= work_ff[5];
         work_ff[7] <= work_ff[6];
      end
   end

   assign status.fill      = fill_ff;
   assign status.last_full = (valid_bytes >= 3'd4);

   assign rsp_tdata = {5'b0, cmd.out_idx, hash_ff[cmd.out_idx]};

endmodule

`default_nettype wire

// File: design/sha256_ctrl.sv
`default_nettype none

`include "assert_macros.svh"

module sha256_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic                        req_tlast,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic                             rsp_tlast,
   input  wire sha256_pkg::sha_status_type  status,
   output sha256_pkg::sha_cmd_type          cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_PAD   = 3'd1;
   localparam logic [2:0] S_ROUND = 3'd2;
   localparam logic [2:0] S_FOLD  = 3'd3;
   localparam logic [2:0] S_OUT   = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [5:0] cnt_ff, cnt_in;
   logic       pad_ff, pad_in;
   logic       extra_ff, extra_in;
   logic       lenhi_ff, lenhi_in;
   logic       done_ff, done_in;
   logic       block_full;

   assign block_full = (status.fill == 4'hf);

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      pad_in        = pad_ff;
      extra_in      = extra_ff;
      lenhi_in      = lenhi_ff;
      done_in       = done_ff;
      req_tready    = 1'b0;
      rsp_tvalid    = 1'b0;
      cmd           = '0;
      cmd.src       = sha256_pkg::SRC_ZERO;
      cmd.round_idx = cnt_ff;
      cmd.out_idx   = cnt_ff[2:0];
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.push      = 1'b1;
               cmd.count     = 1'b1;
               cmd.src       = req_tlast ? sha256_pkg::SRC_LAST : sha256_pkg::SRC_DATA;
               cmd.load_work = block_full;
               pad_in        = req_tlast;
               extra_in      = req_tlast && status.last_full;
               lenhi_in      = 1'b0;
               done_in       = 1'b0;
               cnt_in        = 6'd0;
               if (block_full) begin
                  state_in = S_ROUND;
               end else if (req_tlast) begin
                  state_in = S_PAD;
               end
            end
         end
         S_PAD: begin
            cmd.push = 1'b1;
            if (extra_ff) begin
               cmd.src  = sha256_pkg::SRC_PAD;
               extra_in = 1'b0;
            end else if (status.fill == 4'he) begin
               cmd.src  = sha256_pkg::SRC_LEN_HI;
               lenhi_in = 1'b1;
            end else if (block_full && lenhi_ff) begin
               cmd.src = sha256_pkg::SRC_LEN_LO;
               done_in = 1'b1;
            end
            if (block_full) begin
               cmd.load_work = 1'b1;
               cnt_in        = 6'd0;
               state_in      = S_ROUND;
            end
         end
         S_ROUND: begin
            cmd.round = 1'b1;
            cnt_in    = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               state_in = S_FOLD;
            end
         end
         S_FOLD: begin
            cmd.fold = 1'b1;
            cnt_in   = 6'd0;
            if (done_ff) begin
               state_in = S_OUT;
            end else if (pad_ff) begin
               state_in = S_PAD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               cnt_in = cnt_ff + 6'd1;
               if (cnt_ff[2:0] == 3'd7) begin
                  cmd.restart = 1'b1;
                  cnt_in      = 6'd0;
                  pad_in      = 1'b0;
                  done_in     = 1'b0;
                  lenhi_in    = 1'b0;
                  state_in    = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_tlast = (cnt_ff[2:0] == 3'd7);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= 6'd0;
         pad_ff   <= 1'b0;
         extra_ff <= 1'b0;
         lenhi_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         pad_ff   <= pad_in;
         extra_ff <= extra_in;
         lenhi_ff <= lenhi_in;
         done_ff  <= done_in;
      end
   end

   `ASSERT_IMPLIES(a_no_overlap, clock, reset, rsp_tvalid, !req_tready)
   `ASSERT_IMPLIES(a_full_loads, clock, reset, cmd.push && block_full, cmd.load_work)
   `ASSERT_NEXT(a_round_end, clock, reset, state_ff == S_ROUND && cnt_ff == 6'd63,
                state_ff == S_FOLD)
   `ASSERT_NEXT(a_out_end, clock, reset, rsp_tvalid && rsp_tready && rsp_tlast,
                state_ff == S_IDLE && status.fill == 4'h0)
   `ASSERT_IMPLIES(a_len_order, clock, reset, cmd.src == sha256_pkg::SRC_LEN_LO && cmd.push,
                   lenhi_ff && block_full)

endmodule

`default_nettype wire

// File: design/sha256_message_hash.sv
// Streaming SHA-256 hasher.
// req channel: one message word per item, first byte in tdata[31:24];
//   tlast marks the final word, whose valid byte count (0..4) sits in
//   tdata[34:32] and is ignored on earlier words.
// rsp channel: eight digest words H0..H7 after each final word, tdata[34:32]
//   giving the word index and tlast set on H7.
// The sixteenth word of a block starts the compression: one round per
//   cycle on a single round unit, 64 rounds followed by one fold step.
// After the final word the block pushes padding and the 64-bit length one
//   word per cycle and runs one or two more compressions; digest words
//   follow, one per cycle while rsp_tready is high.
// No new word is accepted while padding, compressing or emitting. A stalled
//   receiver holds the current digest word on the port. The next message
//   starts from the initial hash once H7 is taken.
// Reset (synchronous) loads the initial hash, clears the bit counter and
//   the word count, and leaves the block idle and ready.
`default_nettype none

module sha256_message_hash (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,  // data_word[31:0], valid_bytes[34:32], zero
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,  // digest_word[31:0], word_index[34:32], zero
   output logic             rsp_tlast
);

   sha256_pkg::sha_cmd_type    cmd;
   sha256_pkg::sha_status_type status;

   sha256_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tlast  (rsp_tlast),
      .status     (status),
      .cmd        (cmd)
   );

   sha256_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tdata (rsp_tdata),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

`default_nettype wire

// File: test/tb_sha256_message_hash.sv
`timescale 1ns / 100ps

package digest_check_pkg;

   localparam logic [31:0] SHA_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] SHA_IV [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   typedef struct packed {
      logic [31:0] digest;
      logic [2:0]  index;
      logic        last_flag;
   } digest_item_type;

   class digest_scoreboard;
      logic [31:0]     chain [8];
      logic [31:0]     block [16];
      int unsigned     fill;
      logic [63:0]     msg_bits;
      digest_item_type pending_digests [$];
      int unsigned     mismatches;

      function new();
         mismatches = 0;
         restart();
      endfunction

      function void restart();
         for (int i = 0; i < 8; i++) chain[i] = SHA_IV[i];
         fill = 0;
         msg_bits = '0;
      endfunction

      function logic [31:0] ror32(logic [31:0] x, int unsigned n);
         logic [63:0] dbl;
         dbl = {x, x} >> n;
         return dbl[31:0];
      endfunction

      function void compress();
         logic [31:0] sched [64];
         logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
         for (int i = 0; i < 16; i++) sched[i] = block[i];
         for (int i = 16; i < 64; i++) begin
            s0 = ror32(sched[i-15], 7) ^ ror32(sched[i-15], 18) ^ (sched[i-15] >> 3);
            s1 = ror32(sched[i-2], 17) ^ ror32(sched[i-2], 19) ^ (sched[i-2] >> 10);
            sched[i] = s1 + sched[i-7] + s0 + sched[i-16];
         end
         a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
         e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
         for (int i = 0; i < 64; i++) begin
            t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
                 + SHA_K[i] + sched[i];
            t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
         end
         chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
         chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
      endfunction

      function void absorb(logic [31:0] w);
         block[fill] = w;
         fill = (fill + 1) % 16;
         if (fill == 0) compress();
      endfunction

      function void note_word(logic [31:0] word, logic [2:0] nbytes, logic is_end);
         int unsigned     nb;
         digest_item_type item;
         if (!is_end) begin
            absorb(word);
            msg_bits += 64'd32;
            return;
         end
         nb = (nbytes > 3'd4) ? 4 : int'(nbytes);
         msg_bits += 64'(8 * nb);
         if (nb == 4) begin
            absorb(word);
            absorb(32'h8000_0000);
         end else begin
            absorb((word & ~(32'hffff_ffff >> (8 * nb))) | (32'h80 << (24 - 8 * nb)));
         end
         if (fill == 15) absorb(32'h0);
         while (fill != 14) absorb(32'h0);
         absorb(msg_bits[63:32]);
         absorb(msg_bits[31:0]);
         for (int k = 0; k < 8; k++) begin
            item.digest = chain[k];
            item.index = 3'(k);
            item.last_flag = (k == 7);
            pending_digests.push_back(item);
         end
         restart();
      endfunction

      function void check_digest(logic [31:0] digest, logic [2:0] index, logic last_flag);
         digest_item_type want;
         if (pending_digests.size() == 0) begin
            $error("unexpected digest item: digest_word %h word_index %0d", digest, index);
            mismatches++;
            return;
         end
         want = pending_digests.pop_front();
         if (digest !== want.digest) begin
            $error("digest_word: expected %h, actual %h", want.digest, digest);
            mismatches++;
         end
         if (index !== want.index) begin
            $error("word_index: expected %0d, actual %0d", want.index, index);
            mismatches++;
         end
         if (last_flag !== want.last_flag) begin
            $error("last_word: expected %0b, actual %0b", want.last_flag, last_flag);
            mismatches++;
         end
      endfunction

      function int unsigned pending();
         return pending_digests.size();
      endfunction
   endclass

endpackage

module tb_sha256_message_hash;

   localparam int unsigned CYCLE_LIMIT = 600_000;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   bit          hold_request = 1'b0;
   int unsigned cycle_count = 0;

   digest_check_pkg::digest_scoreboard digests = new();

   sha256_message_hash u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      int unsigned hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            digests.check_digest(rsp_tdata[31:0], rsp_tdata[34:32], rsp_tlast);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = 400;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   task automatic send_word(input logic [31:0] word, input logic [2:0] nbytes,
                            input logic is_end);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {5'b0, nbytes, word};
      req_tlast <= is_end;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      digests.note_word(word, nbytes, is_end);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (digests.pending() != 0) @(posedge clock);
   endtask

   task automatic random_messages(input int unsigned s_pct, input int unsigned r_pct,
                                  input int unsigned quota);
      int unsigned sent;
      int unsigned len;
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      sent = 0;
      while (sent < quota) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(40, 16) : $urandom_range(15, 0);
         for (int i = 0; i < len; i++)
            send_word($urandom, 3'($urandom_range(7, 0)), 1'b0);
         send_word($urandom, 3'($urandom_range(7, 0)), 1'b1);
         sent += len + 1;
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 31;
      recv_idle_pct = 86;
      send_word(32'hffff_ffff, 3'd0, 1'b1);
      send_word(32'h6162_63ff, 3'd3, 1'b1);
      send_word(32'h0000_0000, 3'd4, 1'b1);
      send_word(32'hffff_ffff, 3'd4, 1'b1);
      send_word(32'h1234_5678, 3'd5, 1'b1);
      send_word(32'h8765_4321, 3'd6, 1'b1);
      send_word(32'hffff_ffff, 3'd7, 1'b1);
      send_word(32'hdead_beef, 3'd1, 1'b1);
      send_word(32'hcafe_f00d, 3'd2, 1'b1);
      for (int i = 0; i < 13; i++)
         send_word((i % 2 == 0) ? 32'hffff_ffff : 32'h0000_0000, 3'(i), 1'b0);
      send_word(32'ha5a5_5a5a, 3'd4, 1'b1);
      drain();

      random_messages(31, 86, 129);
      drain();
      random_messages(86, 31, 129);
      drain();
      hold_request = 1'b1;
      random_messages(0, 0, 129);
      drain();

      repeat (200) @(posedge clock);
      if (digests.mismatches == 0 && digests.pending() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// File: sha256_message_hash.f
+incdir+design
design/sha256_pkg.sv
design/sha256_dp.sv
design/sha256_ctrl.sv
design/sha256_message_hash.sv
test/tb_sha256_message_hash.sv
